// ===== rtl/gb_pkg.sv =====
// Shared types, constants and tap-index functions for the 5x5 Gaussian filter.
package gb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINES_KEPT = 4;
  localparam int WIN        = 5;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WUSE_W    = $clog2(MAX_WIDTH + 1);
  localparam int WID_W     = 11;
  localparam int HGT_W     = 13;
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PX_W      = 24;
  localparam int LS_W      = PX_W * LINES_KEPT;

  localparam int ROWS_W = 15;
  localparam int SUM_W  = 17;
  localparam int RCP_W  = 18;
  localparam int PROD_W = SUM_W + RCP_W;

  // floor(s / 273) == (s * RECIP) >> RECIP_SH for every s below 2^17
  localparam logic [RCP_W-1:0] RECIP    = 18'd245821;
  localparam int               RECIP_SH = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } px_t;

  localparam logic [5:0] KERN [WIN][WIN] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  // Position of the item that loaded the window, reduced to border flags
  typedef struct packed {
    logic       r_ge2;
    logic       c_ge2;
    logic       c_last;
    logic       c_small;
    logic [1:0] c_lo;
    logic       r_small;
    logic [1:0] r_lo;
    logic       r_at_h;
    logic       r_at_h1;
  } pos_t;

  // Load enables of the arithmetic stages
  typedef struct packed {
    logic d;
    logic e;
    logic f;
  } en_t;

  // Window column for kernel column dx of the result that is e columns right
  // of the plain position; reflects at the left and right frame edges.
  function automatic logic [2:0] col_idx(pos_t p, logic [1:0] e, int dx);
    int d;
    int v;
    d = dx - 2;
    if (p.c_small && (int'(p.c_lo) + int'(e) + d < 2)) begin
      v = 6 - 2 * int'(p.c_lo) - int'(e) - d;
    end else if (p.c_last && (int'(e) + d >= 3)) begin
      v = 6 - int'(e) - d;
    end else begin
      v = 2 + int'(e) + d;
    end
    return 3'(v);
  endfunction

  // Window row for kernel row dy; reflects at the top and bottom frame edges.
  function automatic logic [2:0] row_idx(pos_t p, int dy);
    int d;
    int v;
    d = dy - 2;
    if (p.r_small && (int'(p.r_lo) + d < 2)) begin
      v = 6 - 2 * int'(p.r_lo) - d;
    end else if (p.r_at_h && d >= 2) begin
      v = 4 - d;
    end else if (p.r_at_h1 && d >= 1) begin
      v = 2 - d;
    end else begin
      v = 2 + d;
    end
    return 3'(v);
  endfunction

endpackage

// ===== rtl/gb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gb_col_cell.sv =====
// One window column cell: holds five pixels and takes its right neighbor's column on shift.
module gb_col_cell import gb_pkg::*; (
  input  logic clk,
  input  logic shift,
  input  px_t  col_in [WIN],
  output px_t  col_q  [WIN]
);

  px_t col_r [WIN];

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_q = col_r;

endmodule

// ===== rtl/gb_kernel.sv =====
// Weighted 5x5 sum of one color channel and division by 273, three register stages.
module gb_kernel import gb_pkg::*; (
  input  logic       clk,
  input  en_t        en,
  input  logic [7:0] taps [WIN][WIN],
  output logic [7:0] q
);

  logic [ROWS_W-1:0] rows_nxt [WIN];
  logic [ROWS_W-1:0] rows_r   [WIN];
  logic [SUM_W-1:0]  tot_nxt;
  logic [SUM_W-1:0]  tot_r;
  logic [PROD_W-1:0] prod;
  logic [7:0]        q_r;

  always_comb begin
    for (int dy = 0; dy < WIN; dy++) begin
      rows_nxt[dy] = '0;
      for (int dx = 0; dx < WIN; dx++) begin
        rows_nxt[dy] = rows_nxt[dy] +
                       ROWS_W'(KERN[dy][dx]) * ROWS_W'(taps[dy][dx]);
      end
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int dy = 0; dy < WIN; dy++) begin
      tot_nxt = tot_nxt + SUM_W'(rows_r[dy]);
    end
  end

  assign prod = PROD_W'(tot_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en.d) begin
      rows_r <= rows_nxt;
    end
    if (en.e) begin
      tot_r <= tot_nxt;
    end
    if (en.f) begin
      q_r <= prod[RECIP_SH +: 8];
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/gaussian_5x5_rgb_filter.sv =====
// Top level of the streaming 5x5 Gaussian RGB filter.
//
// Pixels enter on the in_ channel in row order, one transaction each; in_tuser
// marks a flush transaction. After the last image row, 2*width flush transactions
// drain the bottom two rows. Results leave on the out_ channel: out_tlast marks
// the last result caused by one input transaction, out_tuser the final pixel
// of the frame. A flush sent while image rows are still expected is taken and
// dropped. Frame size comes from the cfg_ port; a write restarts the frame.
// Throughput: one input transaction per cycle while the receiver keeps up; the
// last pixel of a row (from the third row on) gives three results and holds
// the input while the other two are emitted, since all three come from one
// window position. An input passes through line store read, window shift, tap
// select, row sums, total and divide into the output register; the extra
// results of a row end follow one per cycle while the receiver takes them.
// Results lag the input by two rows and two columns.
// When the receiver stalls, the pipeline stages fill up one by one and the
// input is held once the last free stage is taken.
// Reset empties the pipeline, clears the counters and sets the size to 256x256;
// the line store needs no clearing pass.
module gaussian_5x5_rgb_filter import gb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // in_red, in_green, in_blue
  input  logic                 in_tuser,   // kind
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // out_red, out_green, out_blue
  output logic                 out_tlast,  // run_last
  output logic                 out_tuser,  // frame_end
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // configuration and position counters
  logic [WID_W-1:0]  img_w_r, img_w_nxt;
  logic [HGT_W-1:0]  img_h_r, img_h_nxt;
  logic [WUSE_W-1:0] w_use;
  logic [ROW_W-1:0]  h_row;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic in_acc, ignore, live;
  px_t  pix;
  pos_t pos;

  // stage A: line store read in flight
  logic             a_v_r, a_v_nxt;
  px_t              a_pix_r;
  logic [COL_W-1:0] a_c_r;
  pos_t             a_pos_r;
  logic             ab_move;

  logic [LS_W-1:0] ls_rdata, ls_wdata;

  // stage B: window and result job
  px_t        col_new [WIN];
  px_t        win_col [WIN][WIN];
  logic [1:0] b_pend_r, b_pend_nxt;
  logic [1:0] b_e_r, b_e_nxt;
  pos_t       b_pos_r;
  logic       b_ld_ok, emit;

  // stage C: selected taps
  logic c_v_r, c_v_nxt, c_rdy;
  px_t  tap_r [WIN][WIN];
  logic c_last_r, c_fe_r;
  logic [7:0] tap_red [WIN][WIN];
  logic [7:0] tap_grn [WIN][WIN];
  logic [7:0] tap_blu [WIN][WIN];

  // stages D, E, F
  logic d_v_r, d_v_nxt, d_rdy, d_last_r, d_fe_r;
  logic e_v_r, e_v_nxt, e_rdy, e_last_r, e_fe_r;
  logic f_v_r, f_v_nxt, f_rdy, f_last_r, f_fe_r;
  en_t  en;
  logic [7:0] q_red, q_grn, q_blu;

  always_comb begin
    if (img_w_r < WID_W'(3)) begin
      w_use = WUSE_W'(3);
    end else if (int'(img_w_r) > MAX_WIDTH) begin
      w_use = WUSE_W'(MAX_WIDTH);
    end else begin
      w_use = WUSE_W'(img_w_r);
    end
    if (img_h_r < HGT_W'(3)) begin
      h_row = ROW_W'(3);
    end else if (int'(img_h_r) > MAX_HEIGHT) begin
      h_row = ROW_W'(MAX_HEIGHT);
    end else begin
      h_row = ROW_W'(img_h_r);
    end
  end

  assign in_acc = in_tvalid && in_tready;
  assign ignore = (in_tuser == KIND_FLUSH) && (row_r < h_row);
  assign live   = in_acc && !ignore;

  // samples count only while image rows are expected
  always_comb begin
    if (row_r < h_row) begin
      pix.red   = in_tdata[7:0];
      pix.green = in_tdata[15:8];
      pix.blue  = in_tdata[23:16];
    end else begin
      pix = '0;
    end
  end

  always_comb begin
    pos.r_ge2   = row_r >= ROW_W'(2);
    pos.c_ge2   = col_r >= COL_W'(2);
    pos.c_last  = WUSE_W'(col_r) == (w_use - WUSE_W'(1));
    pos.c_small = col_r < COL_W'(4);
    pos.c_lo    = col_r[1:0];
    pos.r_small = row_r < ROW_W'(4);
    pos.r_lo    = row_r[1:0];
    pos.r_at_h  = row_r == h_row;
    pos.r_at_h1 = row_r == (h_row + ROW_W'(1));
  end

  always_comb begin
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  img_w_nxt = cfg_wdata[WID_W-1:0];
        REG_HEIGHT: img_h_nxt = cfg_wdata[HGT_W-1:0];
        default:    img_w_nxt = img_w_r;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (live) begin
      if ((WUSE_W'(col_r) + WUSE_W'(1)) == w_use) begin
        col_nxt = '0;
        if ((row_r + ROW_W'(1)) == (h_row + ROW_W'(2))) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // stage A
  assign ab_move   = a_v_r && b_ld_ok;
  assign in_tready = !a_v_r || b_ld_ok;
  assign a_v_nxt   = live ? 1'b1 : (ab_move ? 1'b0 : a_v_r);

  always_comb begin
    ls_wdata[(LINES_KEPT-1)*PX_W +: PX_W] = a_pix_r;
    for (int i = 0; i < LINES_KEPT - 1; i++) begin
      ls_wdata[i*PX_W +: PX_W] = ls_rdata[(i+1)*PX_W +: PX_W];
    end
  end

  gb_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ab_move),
    .waddr (a_c_r),
    .wdata (ls_wdata),
    .re    (live),
    .raddr (col_r),
    .rdata (ls_rdata)
  );

  // stage B: the window is a chain of column cells, new column enters on the right
  always_comb begin
    for (int i = 0; i < LINES_KEPT; i++) begin
      col_new[i] = ls_rdata[i*PX_W +: PX_W];
    end
    col_new[WIN-1] = a_pix_r;
  end

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    if (k == WIN - 1) begin : g_head
      gb_col_cell u_cell (
        .clk    (clk),
        .shift  (ab_move),
        .col_in (col_new),
        .col_q  (win_col[k])
      );
    end else begin : g_body
      gb_col_cell u_cell (
        .clk    (clk),
        .shift  (ab_move),
        .col_in (win_col[k+1]),
        .col_q  (win_col[k])
      );
    end
  end

  assign emit    = (b_pend_r != 2'd0) && c_rdy;
  assign b_ld_ok = (b_pend_r == 2'd0) || ((b_pend_r == 2'd1) && c_rdy);

  always_comb begin
    b_pend_nxt = b_pend_r;
    b_e_nxt    = b_e_r;
    if (ab_move) begin
      b_e_nxt = 2'd0;
      if (a_pos_r.r_ge2) begin
        b_pend_nxt = (a_pos_r.c_ge2 ? 2'd1 : 2'd0) + (a_pos_r.c_last ? 2'd2 : 2'd0);
      end else begin
        b_pend_nxt = 2'd0;
      end
    end else if (emit) begin
      b_pend_nxt = b_pend_r - 2'd1;
      b_e_nxt    = b_e_r + 2'd1;
    end
  end

  // stage C onward: elastic pipeline
  assign f_rdy = !f_v_r || out_tready;
  assign e_rdy = !e_v_r || f_rdy;
  assign d_rdy = !d_v_r || e_rdy;
  assign c_rdy = !c_v_r || d_rdy;

  assign en.d = c_v_r && d_rdy;
  assign en.e = d_v_r && e_rdy;
  assign en.f = e_v_r && f_rdy;

  assign c_v_nxt = emit ? 1'b1 : (en.d ? 1'b0 : c_v_r);
  assign d_v_nxt = en.d ? 1'b1 : (en.e ? 1'b0 : d_v_r);
  assign e_v_nxt = en.e ? 1'b1 : (en.f ? 1'b0 : e_v_r);
  assign f_v_nxt = en.f ? 1'b1 : ((f_v_r && out_tready) ? 1'b0 : f_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= WID_W'(256);
      img_h_r  <= HGT_W'(256);
      col_r    <= '0;
      row_r    <= '0;
      a_v_r    <= 1'b0;
      b_pend_r <= 2'd0;
      b_e_r    <= 2'd0;
      c_v_r    <= 1'b0;
      d_v_r    <= 1'b0;
      e_v_r    <= 1'b0;
      f_v_r    <= 1'b0;
    end else begin
      img_w_r  <= img_w_nxt;
      img_h_r  <= img_h_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      a_v_r    <= a_v_nxt;
      b_pend_r <= b_pend_nxt;
      b_e_r    <= b_e_nxt;
      c_v_r    <= c_v_nxt;
      d_v_r    <= d_v_nxt;
      e_v_r    <= e_v_nxt;
      f_v_r    <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (live) begin
      a_pix_r <= pix;
      a_c_r   <= col_r;
      a_pos_r <= pos;
    end
    if (ab_move) begin
      b_pos_r <= a_pos_r;
    end
    if (emit) begin
      for (int dy = 0; dy < WIN; dy++) begin
        for (int dx = 0; dx < WIN; dx++) begin
          tap_r[dy][dx] <= win_col[col_idx(b_pos_r, b_e_r, dx)][row_idx(b_pos_r, dy)];
        end
      end
      c_last_r <= b_pend_r == 2'd1;
      c_fe_r   <= b_pos_r.r_at_h1 && b_pos_r.c_last && (b_e_r == 2'd2);
    end
    if (en.d) begin
      d_last_r <= c_last_r;
      d_fe_r   <= c_fe_r;
    end
    if (en.e) begin
      e_last_r <= d_last_r;
      e_fe_r   <= d_fe_r;
    end
    if (en.f) begin
      f_last_r <= e_last_r;
      f_fe_r   <= e_fe_r;
    end
  end

  always_comb begin
    for (int dy = 0; dy < WIN; dy++) begin
      for (int dx = 0; dx < WIN; dx++) begin
        tap_red[dy][dx] = tap_r[dy][dx].red;
        tap_grn[dy][dx] = tap_r[dy][dx].green;
        tap_blu[dy][dx] = tap_r[dy][dx].blue;
      end
    end
  end

  gb_kernel u_kern_red (.clk(clk), .en(en), .taps(tap_red), .q(q_red));
  gb_kernel u_kern_grn (.clk(clk), .en(en), .taps(tap_grn), .q(q_grn));
  gb_kernel u_kern_blu (.clk(clk), .en(en), .taps(tap_blu), .q(q_blu));

  assign out_tvalid = f_v_r;
  assign out_tdata  = {q_blu, q_grn, q_red};
  assign out_tlast  = f_last_r;
  assign out_tuser  = f_fe_r;

endmodule

// ===== rtl/gb_checker.sv =====
// Port-level checks for the Gaussian filter, bound to the top level.
module gb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // frame end is always the last result of its input transaction
  a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without run end");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // no result can come out just after reset is released
  a_rst_lat: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |=> !out_tvalid)
    else $error("result too soon after reset");

endmodule

bind gaussian_5x5_rgb_filter gb_checker u_gb_checker (.*);
